FILE: rtl/core/html_href_extractor_assert.svh
// Assertion macros for the href extractor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HTML_HREF_EXTRACTOR_ASSERT_SVH
`define HTML_HREF_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HHE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("href extractor check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("href extractor check failed");

`endif

FILE: rtl/core/hhe_pkg.sv
// Package for the href extractor: scanner state codes, character constants,
// URL capacity and the result struct. Depends on nothing.
package hhe_pkg;

   // Largest URL buffer, counting one slot kept free; at most URL_MAX-1 bytes are kept.
   localparam int URL_MAX = 256;
   localparam logic [7:0] URL_KEEP_MAX = 8'(URL_MAX - 1);

   // Scanner state codes.
   localparam logic [3:0] S_START    = 4'd0;
   localparam logic [3:0] S_LEFT     = 4'd1;
   localparam logic [3:0] S_TAGBEGIN = 4'd2;
   localparam logic [3:0] S_ATAG     = 4'd3;
   localparam logic [3:0] S_OTAG     = 4'd4;
   localparam logic [3:0] S_HREF     = 4'd5;
   localparam logic [3:0] S_HREF1    = 4'd6;
   localparam logic [3:0] S_HREF2    = 4'd7;
   localparam logic [3:0] S_HREF3    = 4'd8;
   localparam logic [3:0] S_HREF4    = 4'd9;
   localparam logic [3:0] S_URLB     = 4'd10;
   localparam logic [3:0] S_URLE     = 4'd11;

   // Characters the scanner looks for.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CASE_BIT = 8'h20;

   // One result item as produced by the scanner.
   typedef struct packed {
      logic       valid;
      logic [7:0] url_byte;
      logic       url_end;
      logic [7:0] url_length;
      logic       truncated;
   } hhe_result_type;

   // Case-insensitive match of a byte against a lower-case letter.
   function automatic logic is_letter(input logic [7:0] c, input logic [7:0] lower);
      return (c | CASE_BIT) == lower;
   endfunction

endpackage

FILE: rtl/core/hhe_scan.sv
// Href scanner: state register, URL byte count and overflow flag, with the
// next-state and result logic for one byte. Depends on hhe_pkg and html_href_extractor_assert.svh.
`include "html_href_extractor_assert.svh"

module hhe_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  logic [7:0]            step_byte,
   output hhe_pkg::hhe_result_type result
);
   import hhe_pkg::*;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic       overflow_ff;
   logic       overflow_in;
   hhe_result_type res;

   // Next state, count and result for the byte being processed.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      res         = '0;
      if (step_valid && step_byte != CH_NUL) begin
         unique case (state_ff)
            S_LEFT: begin
               if (step_byte == CH_SPACE) state_in = S_START;
               else if (is_letter(step_byte, CH_A)) state_in = S_TAGBEGIN;
               else state_in = S_URLE;
            end
            S_TAGBEGIN: begin
               state_in = (step_byte == CH_SPACE) ? S_ATAG : S_URLE;
            end
            S_ATAG: begin
               if (step_byte == CH_GT) state_in = S_START;
               else if (is_letter(step_byte, CH_H)) state_in = S_HREF;
               else if (step_byte == CH_SPACE) state_in = S_ATAG;
               else state_in = S_OTAG;
            end
            S_OTAG: begin
               if (step_byte == CH_SPACE) state_in = S_ATAG;
            end
            S_HREF: begin
               state_in = is_letter(step_byte, CH_R) ? S_HREF1 : S_OTAG;
            end
            S_HREF1: begin
               state_in = is_letter(step_byte, CH_E) ? S_HREF2 : S_OTAG;
            end
            S_HREF2: begin
               state_in = is_letter(step_byte, CH_F) ? S_HREF3 : S_OTAG;
            end
            S_HREF3: begin
               if (step_byte == CH_SPACE) state_in = S_HREF3;
               else if (step_byte == CH_EQ) state_in = S_HREF4;
               else state_in = S_OTAG;
            end
            S_HREF4: begin
               if (step_byte == CH_SPACE) begin
                  state_in = S_HREF4;
               end else if (step_byte == CH_QUOTE) begin
                  state_in    = S_URLB;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end else begin
                  state_in = S_OTAG;
               end
            end
            S_URLB: begin
               if (step_byte == CH_QUOTE) begin
                  state_in       = S_URLE;
                  res.valid      = 1'b1;
                  res.url_end    = 1'b1;
                  res.url_length = count_ff;
                  res.truncated  = overflow_ff;
               end else if (count_ff < URL_KEEP_MAX) begin
                  count_in       = count_ff + 8'd1;
                  res.valid      = 1'b1;
                  res.url_byte   = step_byte;
                  res.url_length = count_ff + 8'd1;
                  res.truncated  = overflow_ff;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            S_URLE: begin
               if (step_byte == CH_GT) state_in = S_START;
            end
            default: begin
               // Start and any unused code: wait for a tag opening.
               state_in = (step_byte == CH_LT) ? S_LEFT : S_START;
            end
         endcase
      end
   end

   assign result = res;

   // Scanner registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_START;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // The kept count never passes the capacity.
   `HHE_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= URL_KEEP_MAX)
   // A byte is dropped only once the buffer is full.
   `HHE_ASSERT_NOW(a_overflow_full, clock, reset, overflow_ff, count_ff == URL_KEEP_MAX)
   // A closing quote ends the URL and leaves the scanner after the value.
   `HHE_ASSERT_NEXT(a_quote_ends, clock, reset,
      step_valid && state_ff == S_URLB && step_byte == CH_QUOTE, state_ff == S_URLE)

endmodule

FILE: rtl/core/hhe_rsp_reg.sv
// Result register for the href extractor: holds one result item until the
// consumer takes it. Depends on hhe_pkg.
module hhe_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hhe_pkg::hhe_result_type load_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_url_byte,
   output logic                  rsp_url_end,
   output logic [7:0]            rsp_url_length,
   output logic                  rsp_truncated,
   output logic                  free
);
   import hhe_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   hhe_result_type data_ff;

   // The register can take a new item when empty or being emptied this cycle.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_url_byte   = data_ff.url_byte;
   assign rsp_url_end    = data_ff.url_end;
   assign rsp_url_length = data_ff.url_length;
   assign rsp_truncated  = data_ff.truncated;

endmodule

FILE: rtl/core/html_href_extractor.sv
// Href extractor top level: input register, scanner and result register.
// Depends on hhe_pkg, hhe_scan and hhe_rsp_reg.
//
// Takes one HTML text byte per cycle on the req_ channel and returns the
// characters of each href value of an anchor tag on the rsp_ channel, followed
// by one end item carrying the URL length. The sustained rate is one byte per
// cycle. An accepted byte is held in the input register and is scanned as it
// moves on, when the result register has room; any result it gives is loaded
// into the result register, which drives rsp_valid. Throughput drops only
// while the consumer holds rsp_ready low with a result waiting.
module html_href_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_url_byte,
   output logic       rsp_url_end,
   output logic [7:0] rsp_url_length,
   output logic       rsp_truncated
);
   import hhe_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           out_free;
   logic           advance;
   hhe_result_type scan_result;

   // The buffered item moves on whenever the result register has room.
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_data_byte;
   end

   hhe_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .result     (scan_result)
   );

   hhe_rsp_reg u_rsp_reg (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && scan_result.valid),
      .load_data      (scan_result),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_url_byte   (rsp_url_byte),
      .rsp_url_end    (rsp_url_end),
      .rsp_url_length (rsp_url_length),
      .rsp_truncated  (rsp_truncated),
      .free           (out_free)
   );

endmodule
